/* rtl/lmd_pkg.sv */
package lmd_pkg;

  localparam int GRID_COUNT_DEF = 6;

  localparam logic [7:0] HALF_BIT_TICKS_RST = 8'd1;

  // Command bytes of the display driver.
  localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
  localparam logic [7:0] CMD_ADDR      = 8'hC0;
  localparam logic [7:0] CMD_DISP      = 8'h80;

  localparam logic [2:0] BRIGHT_MAX = 3'b111;
  localparam logic       ON_MAX     = 1'b1;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_RAW   = 3'd1,
    REQ_DISP  = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_AUTO  = 3'd4,
    REQ_FIXED = 3'd5,
    REQ_LOAD  = 3'd6
  } req_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] grid_address;
    logic [7:0] write_length;
    logic [7:0] display_on;
    logic [7:0] brightness_level;
    logic       dio_sample;
  } seq_req_t;

  typedef struct packed {
    logic       rejected;
    logic [2:0] error_bits;
    logic       ack_seen;
    logic       busy_res;
    logic       dio_listening;
    logic       dio_high;
    logic       clk_high;
  } seq_status_t;

endpackage

/* rtl/lmd_seq.sv */
module lmd_seq #(
  parameter int GRID_COUNT = lmd_pkg::GRID_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  lmd_pkg::seq_req_t   req,
  input  logic [7:0]          half_bit_ticks,
  output lmd_pkg::seq_status_t status
);
  import lmd_pkg::*;

  localparam int AW  = (GRID_COUNT > 1) ? $clog2(GRID_COUNT) : 1;
  localparam int BIW = $clog2(GRID_COUNT + 2);
  localparam int LW  = $clog2(GRID_COUNT + 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_BIT_A, PH_BIT_B, PH_BIT_C,
    PH_ACK_A, PH_ACK_B, PH_ACK_C, PH_BYTE_END, PH_STOP_A, PH_STOP_B,
    PH_FRAME_END
  } phase_t;

  phase_t           phase, phase_next;
  logic [2:0]       unit_wait, unit_wait_next;
  logic [7:0]       tick_count, tick_count_next;
  logic [3:0]       bit_index, bit_index_next;
  logic [BIW-1:0]   byte_index, byte_index_next;
  logic [LW-1:0]    byte_total, byte_total_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [AW-1:0]    start_address, start_address_next;
  logic [2:0]       active_request, active_request_next;
  logic             frame_no, frame_no_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             clk_level, clk_level_next;
  logic             dio_level, dio_level_next;
  logic             dio_input_mode, dio_input_mode_next;
  logic             ack_bit, ack_bit_next;
  logic [2:0]       error_latch, error_latch_next;
  logic             rejected;

  logic [7:0]       seg_mem [GRID_COUNT];
  logic [7:0]       seg_rd;
  logic [AW-1:0]    seg_rd_addr;
  logic             seg_we;

  logic             busy;
  logic [7:0]       hbt;

  function automatic logic [BIW-1:0] frame_len(input logic [2:0] act, input logic fno,
                                               input logic [LW-1:0] tot);
    if (act == REQ_FIXED) return BIW'(2);
    if (!fno) return BIW'(1);
    if (act == REQ_CLEAR) return BIW'(GRID_COUNT + 1);
    return BIW'(tot) + BIW'(1);
  endfunction

  function automatic logic [7:0] frame_byte(input logic [2:0] act, input logic fno,
                                            input logic [BIW-1:0] idx,
                                            input logic [AW-1:0] sa,
                                            input logic [7:0] held,
                                            input logic [7:0] seg);
    logic [7:0] addr_cmd;
    addr_cmd = CMD_ADDR | 8'(sa);
    if (act == REQ_FIXED) return (idx == '0) ? addr_cmd : held;
    if (act == REQ_RAW || act == REQ_DISP) return held;
    if (!fno) return CMD_DATA_AUTO;
    if (act == REQ_CLEAR) return (idx == '0) ? CMD_ADDR : 8'h00;
    if (idx == '0) return addr_cmd;
    if ((idx - BIW'(1)) < BIW'(GRID_COUNT)) return seg;
    return 8'h00;
  endfunction

  assign busy = (phase != PH_IDLE);
  assign hbt  = (half_bit_ticks == 8'd0) ? 8'd1 : half_bit_ticks;

  // The buffer entry for the next data byte of a frame is the one at the
  // current byte index, so it is read ahead and is ready long before the
  // byte boundary that needs it.
  assign seg_rd_addr = (byte_index < BIW'(GRID_COUNT)) ? byte_index[AW-1:0] : '0;
  assign seg_we = step && !busy && (req.req_type == REQ_LOAD)
                  && (req.grid_address < 8'(GRID_COUNT));

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[req.grid_address[AW-1:0]] <= req.data_byte;
    end
    seg_rd <= seg_mem[seg_rd_addr];
  end

  always_comb begin
    logic [7:0]     tick_inc;
    logic [2:0]     wait_dec;
    logic           run_en;
    logic           done;
    phase_t         ph;
    logic [BIW-1:0] bidx;
    logic [7:0]     addr_c;
    logic [7:0]     room;
    logic [7:0]     len_c;
    logic           on_c;
    logic [2:0]     bright_c;
    logic [2:0]     err;
    logic [3:0]     bit_inc;

    phase_next          = phase;
    unit_wait_next      = unit_wait;
    tick_count_next     = tick_count;
    bit_index_next      = bit_index;
    byte_index_next     = byte_index;
    byte_total_next     = byte_total;
    shift_byte_next     = shift_byte;
    start_address_next  = start_address;
    active_request_next = active_request;
    frame_no_next       = frame_no;
    held_byte_next      = held_byte;
    clk_level_next      = clk_level;
    dio_level_next      = dio_level;
    dio_input_mode_next = dio_input_mode;
    ack_bit_next        = ack_bit;
    error_latch_next    = error_latch;
    rejected            = 1'b0;

    tick_inc = tick_count + 8'd1;
    wait_dec = unit_wait;
    run_en   = 1'b0;
    done     = 1'b0;
    ph       = phase;
    bidx     = byte_index;
    addr_c   = req.grid_address;
    room     = 8'd0;
    len_c    = req.write_length;
    on_c     = req.display_on[0];
    bright_c = req.brightness_level[2:0];
    err      = 3'd0;
    bit_inc  = bit_index + 4'd1;

    if (step) begin
      if (req.req_type == REQ_TICK) begin
        if (busy) begin
          if (tick_inc >= hbt) begin
            tick_count_next = 8'd0;
            if (unit_wait != 3'd0) wait_dec = unit_wait - 3'd1;
            unit_wait_next = wait_dec;
            run_en = (wait_dec == 3'd0);
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end else if (req.req_type <= REQ_LOAD) begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          if (req.req_type == REQ_AUTO || req.req_type == REQ_FIXED) begin
            if (req.grid_address > 8'(GRID_COUNT - 1)) begin
              addr_c = 8'(GRID_COUNT - 1);
              err[0] = 1'b1;
            end
            start_address_next = addr_c[AW-1:0];
          end
          case (req.req_type)
            REQ_RAW, REQ_FIXED: begin
              held_byte_next = req.data_byte;
            end
            REQ_DISP: begin
              if (req.display_on > 8'd1) begin
                on_c = ON_MAX;
                err[0] = 1'b1;
              end
              if (req.brightness_level > 8'(BRIGHT_MAX)) begin
                bright_c = BRIGHT_MAX;
                err[1] = 1'b1;
              end
              held_byte_next = CMD_DISP | {4'd0, on_c, bright_c};
            end
            REQ_AUTO: begin
              room = 8'(GRID_COUNT) - addr_c;
              if (req.write_length > room) begin
                len_c = room;
                err[1] = 1'b1;
              end else if (req.write_length == 8'd0) begin
                len_c = 8'd1;
                err[2] = 1'b1;
              end
              byte_total_next = len_c[LW-1:0];
            end
            REQ_LOAD: begin
              if (req.grid_address >= 8'(GRID_COUNT)) err[0] = 1'b1;
            end
            default: begin
            end
          endcase
          if (req.req_type != REQ_LOAD) begin
            active_request_next = req.req_type;
            frame_no_next = 1'b0;
            run_en = 1'b1;
            ph = PH_START_A;
          end
          error_latch_next = err;
        end
      end
    end

    if (run_en) begin
      if (ph == PH_FRAME_END) begin
        if (!frame_no_next && (active_request_next == REQ_CLEAR ||
                               active_request_next == REQ_AUTO)) begin
          frame_no_next = 1'b1;
          ph = PH_START_A;
        end else begin
          phase_next = PH_IDLE;
          unit_wait_next = 3'd0;
          tick_count_next = 8'd0;
          done = 1'b1;
        end
      end
      if (!done && ph == PH_BYTE_END) begin
        bidx = byte_index + BIW'(1);
        byte_index_next = bidx;
        if (bidx < frame_len(active_request_next, frame_no_next, byte_total_next)) begin
          shift_byte_next = frame_byte(active_request_next, frame_no_next, bidx,
                                       start_address_next, held_byte_next, seg_rd);
          bit_index_next = 4'd0;
          ph = PH_BIT_A;
        end else begin
          ph = PH_STOP_A;
        end
      end
      if (!done) begin
        tick_count_next = 8'd0;
        case (ph)
          PH_START_A: begin
            clk_level_next = 1'b1;
            dio_level_next = 1'b1;
            dio_input_mode_next = 1'b0;
            byte_index_next = '0;
            bit_index_next = 4'd0;
            shift_byte_next = frame_byte(active_request_next, frame_no_next, '0,
                                         start_address_next, held_byte_next, seg_rd);
            unit_wait_next = 3'd2;
            phase_next = PH_START_B;
          end
          PH_START_B: begin
            dio_level_next = 1'b0;
            unit_wait_next = 3'd2;
            phase_next = PH_BIT_A;
          end
          PH_BIT_A: begin
            clk_level_next = 1'b0;
            unit_wait_next = 3'd1;
            phase_next = PH_BIT_B;
          end
          PH_BIT_B: begin
            dio_level_next = shift_byte_next[0];
            dio_input_mode_next = 1'b0;
            unit_wait_next = 3'd1;
            phase_next = PH_BIT_C;
          end
          PH_BIT_C: begin
            clk_level_next = 1'b1;
            shift_byte_next = {1'b0, shift_byte_next[7:1]};
            bit_index_next = bit_inc;
            unit_wait_next = 3'd2;
            phase_next = (bit_inc >= 4'd8) ? PH_ACK_A : PH_BIT_A;
          end
          PH_ACK_A: begin
            clk_level_next = 1'b0;
            dio_input_mode_next = 1'b1;
            unit_wait_next = 3'd4;
            phase_next = PH_ACK_B;
          end
          PH_ACK_B: begin
            clk_level_next = 1'b1;
            unit_wait_next = 3'd2;
            phase_next = PH_ACK_C;
          end
          PH_ACK_C: begin
            ack_bit_next = req.dio_sample;
            clk_level_next = 1'b0;
            unit_wait_next = 3'd2;
            phase_next = PH_BYTE_END;
          end
          PH_STOP_A: begin
            dio_level_next = 1'b0;
            dio_input_mode_next = 1'b0;
            clk_level_next = 1'b1;
            unit_wait_next = 3'd2;
            phase_next = PH_STOP_B;
          end
          default: begin
            dio_level_next = 1'b1;
            unit_wait_next = 3'd2;
            phase_next = PH_FRAME_END;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      unit_wait      <= 3'd0;
      tick_count     <= 8'd0;
      bit_index      <= 4'd0;
      byte_index     <= '0;
      byte_total     <= '0;
      shift_byte     <= 8'd0;
      start_address  <= '0;
      active_request <= 3'd0;
      frame_no       <= 1'b0;
      held_byte      <= 8'd0;
      clk_level      <= 1'b1;
      dio_level      <= 1'b1;
      dio_input_mode <= 1'b0;
      ack_bit        <= 1'b0;
      error_latch    <= 3'd0;
    end else begin
      phase          <= phase_next;
      unit_wait      <= unit_wait_next;
      tick_count     <= tick_count_next;
      bit_index      <= bit_index_next;
      byte_index     <= byte_index_next;
      byte_total     <= byte_total_next;
      shift_byte     <= shift_byte_next;
      start_address  <= start_address_next;
      active_request <= active_request_next;
      frame_no       <= frame_no_next;
      held_byte      <= held_byte_next;
      clk_level      <= clk_level_next;
      dio_level      <= dio_level_next;
      dio_input_mode <= dio_input_mode_next;
      ack_bit        <= ack_bit_next;
      error_latch    <= error_latch_next;
    end
  end

  assign status.clk_high      = clk_level_next;
  assign status.dio_high      = dio_level_next;
  assign status.dio_listening = dio_input_mode_next;
  assign status.busy_res      = (phase_next != PH_IDLE);
  assign status.ack_seen      = ack_bit_next;
  assign status.error_bits    = error_latch_next;
  assign status.rejected      = rejected;

  // Both lines rest high and the timers are cleared whenever no frame runs.
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (clk_level && dio_level && unit_wait == 3'd0
                            && tick_count == 8'd0))
    else $error("idle with lines or timers not at rest");

  a_listen_busy: assert property (@(posedge clk) disable iff (rst)
    dio_input_mode |-> (phase != PH_IDLE))
    else $error("data line left in input mode while idle");

  a_wait_range: assert property (@(posedge clk) disable iff (rst)
    (unit_wait <= 3'd4) && (bit_index <= 4'd8))
    else $error("unit wait or bit index out of range");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    rejected |-> (busy && !seg_we))
    else $error("request rejected while idle or loaded while busy");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (step && !busy && req.req_type != REQ_TICK && req.req_type < REQ_LOAD)
    |=> (phase == PH_START_B && clk_level && dio_level))
    else $error("accepted request did not open a frame");

endmodule

/* rtl/led_display_two_wire_master.sv */
// Master for a two-wire LED display driver. Requests and tick words enter on
// the slave stream (tuser is the request code); every accepted word yields
// exactly one status word on the master stream, one word per clock cycle when
// both sides keep up. A request is taken only while no frame runs and is
// otherwise rejected; tick words advance the start, bit, ack and stop timing,
// with one timing unit lasting half_bit_ticks ticks (0 counts as 1). The
// sequencer updates its state in the cycle a word is accepted, and the status
// word waits in an output register so the next word can enter meanwhile. The
// segment buffer is a small memory with a registered read that is fetched
// ahead of each byte boundary; its entries hold nothing until loaded. The
// timing register must be written only while no frame is in progress.
module led_display_two_wire_master #(
  parameter int GRID_COUNT = lmd_pkg::GRID_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,     // half_bit_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte[7:0], grid_address[15:8], write_length[23:16],
  // display_on[31:24], brightness_level[39:32], dio_sample[40]
  input  logic [47:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,    // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // clk_high[0], dio_high[1], dio_listening[2], busy_res[3], ack_seen[4],
  // error_bits[7:5], rejected[8]
  output logic [15:0] m_axis_tdata
);
  import lmd_pkg::*;

  logic        [7:0] half_bit_ticks;
  logic              step;
  seq_req_t          req;
  seq_status_t       status;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;

  assign req.req_type         = s_axis_tuser;
  assign req.data_byte        = s_axis_tdata[7:0];
  assign req.grid_address     = s_axis_tdata[15:8];
  assign req.write_length     = s_axis_tdata[23:16];
  assign req.display_on       = s_axis_tdata[31:24];
  assign req.brightness_level = s_axis_tdata[39:32];
  assign req.dio_sample       = s_axis_tdata[40];

  lmd_seq #(
    .GRID_COUNT(GRID_COUNT)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .req           (req),
    .half_bit_ticks(half_bit_ticks),
    .status        (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_ticks <= HALF_BIT_TICKS_RST;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        half_bit_ticks <= cfg_wr_data;
      end
      if (step) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {7'd0, status};
    end
  end

endmodule
